// ===== rtl/ptu_pkg.sv =====
`timescale 1ns / 1ps

package ptu_pkg;

  // Default table depth
  localparam int SLOTS_DEF = 256;

  // Operation codes
  localparam logic [1:0] OP_TICK  = 2'd0;
  localparam logic [1:0] OP_SPAWN = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;
  localparam logic [1:0] OP_NOP   = 2'd3;

  // Result status codes
  localparam logic [1:0] STS_OK    = 2'd0;
  localparam logic [1:0] STS_FULL  = 2'd1;
  localparam logic [1:0] STS_RANGE = 2'd2;

  // Configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FORCE_X = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FORCE_Y = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_FORCE_Z = 2'd3;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_TICK,
    ST_SCAN,
    ST_READ,
    ST_DONE
  } ptu_state_t;

  // One table entry as stored in memory
  typedef struct packed {
    logic            alive;
    logic [31:0]     life;
    logic [2:0][31:0] vel;
    logic [2:0][31:0] pos;
  } ptu_slot_t;

  // One result transaction
  typedef struct packed {
    logic [1:0]       status;
    logic [7:0]       slot;
    logic             alive;
    logic [2:0][31:0] pos;
    logic [2:0][31:0] vel;
    logic [31:0]      life;
    logic [8:0]       live_total;
  } ptu_res_t;

  // Tick pipeline status toward the controller
  typedef struct packed {
    logic wr_en;
    logic kill;
    logic busy;
  } ptu_tick_ctl_t;

  // Saturating signed 32-bit add
  function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b);
    logic [32:0] s;
    s = {a[31], a} + {b[31], b};
    if (s[32] != s[31]) begin
      return s[32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
    end
    return s[31:0];
  endfunction

  // (a * dt) >> 16, floor; always fits 32 bits
  function automatic logic [31:0] mul_dt(input logic signed [31:0] a, input logic [15:0] dt);
    logic signed [48:0] p;
    p = a * $signed({1'b0, dt});
    return p[47:16];
  endfunction

endpackage

// ===== rtl/ptu_in_if.sv =====
`timescale 1ns / 1ps

interface ptu_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  op;
  logic [15:0] step_time;
  logic [7:0]  slot_index;
  logic signed [31:0] new_pos_x;
  logic signed [31:0] new_pos_y;
  logic signed [31:0] new_pos_z;
  logic signed [31:0] new_vel_x;
  logic signed [31:0] new_vel_y;
  logic signed [31:0] new_vel_z;
  logic [30:0] new_life;

  modport source (output valid, op, step_time, slot_index, new_pos_x, new_pos_y, new_pos_z,
                  new_vel_x, new_vel_y, new_vel_z, new_life, input ready);
  modport sink (input valid, op, step_time, slot_index, new_pos_x, new_pos_y, new_pos_z,
                new_vel_x, new_vel_y, new_vel_z, new_life, output ready);
endinterface

// ===== rtl/ptu_out_if.sv =====
`timescale 1ns / 1ps

interface ptu_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [7:0]  slot;
  logic        is_alive;
  logic signed [31:0] pos_x_out;
  logic signed [31:0] pos_y_out;
  logic signed [31:0] pos_z_out;
  logic signed [31:0] vel_x_out;
  logic signed [31:0] vel_y_out;
  logic signed [31:0] vel_z_out;
  logic signed [31:0] life_left;
  logic [8:0]  live_total;

  modport source (output valid, status, slot, is_alive, pos_x_out, pos_y_out, pos_z_out,
                  vel_x_out, vel_y_out, vel_z_out, life_left, live_total, input ready);
  modport sink (input valid, status, slot, is_alive, pos_x_out, pos_y_out, pos_z_out,
                vel_x_out, vel_y_out, vel_z_out, life_left, live_total, output ready);
endinterface

// ===== rtl/ptu_cfg_if.sv =====
`timescale 1ns / 1ps

interface ptu_cfg_if;
  logic        valid;
  logic        ready;
  logic [ptu_pkg::CFG_IDX_W-1:0] index;
  logic [31:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/particle_table_update.sv =====
`timescale 1ns / 1ps

// Channel  | Dir | Payload
// in_chan  | in  | op, step_time, slot_index, new_pos_*, new_vel_*, new_life
// out_chan | out | status, slot, is_alive, pos_*_out, vel_*_out, life_left, live_total
// cfg_chan | in  | index (0 active_slots, 1..3 force_x..z), data
//
// Tick: ages and moves the first n entries (n = slots in use), one entry per cycle
// through the single read port and the three-stage update pipeline.
// Spawn scans for the first dead entry and fills it; Read returns one entry.
// A write of active_slots clears the first n entries, one per cycle, while no
// input transaction is taken. Reset leaves the table empty with no clearing pass.
// One input transaction is in work at a time; a result waiting on out_chan
// does not block acceptance of the next transaction.

module particle_table_update #(
  parameter int SLOTS = ptu_pkg::SLOTS_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  ptu_in_if.sink        in_chan,
  ptu_out_if.source     out_chan,
  ptu_cfg_if.sink       cfg_chan
);

  localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CW = $clog2(SLOTS + 1);

  ptu_pkg::ptu_state_t state_r, state_nxt;
  logic [8:0]          act_r;
  logic [2:0][31:0]    force_r;
  logic [CW-1:0]       scan_r, scan_nxt;
  logic [8:0]          live_r, live_nxt;
  logic [15:0]         dt_r;
  ptu_pkg::ptu_slot_t  spawn_r;
  logic                rd_vld_r;
  logic [AW-1:0]       rd_addr_r;
  ptu_pkg::ptu_res_t   res_r, res_nxt;
  ptu_pkg::ptu_res_t   out_r;
  logic                out_vld_r;
  logic                out_load;

  logic                in_fire, cfg_fire;
  logic [16:0]         act_ext, n_full;
  logic [CW-1:0]       n;
  logic                rd_en;
  logic [AW-1:0]       rd_addr;
  logic                wr_en;
  logic [AW-1:0]       wr_addr;
  ptu_pkg::ptu_slot_t  wr_data;
  ptu_pkg::ptu_slot_t  rd_data;
  ptu_pkg::ptu_tick_ctl_t tick_ctl;
  logic [AW-1:0]       tick_waddr;
  ptu_pkg::ptu_slot_t  tick_wdata;

  assign in_fire  = in_chan.valid && in_chan.ready;
  assign cfg_fire = cfg_chan.valid && cfg_chan.ready;
  assign in_chan.ready  = (state_r == ptu_pkg::ST_IDLE);
  assign cfg_chan.ready = 1'b1;

  // Slots in use: active_slots capped at the table depth
  assign act_ext = 17'(act_r);
  assign n_full  = (act_ext >= 17'(SLOTS)) ? 17'(SLOTS) : act_ext;
  assign n       = n_full[CW-1:0];

  ptu_mem #(.DEPTH(SLOTS), .AW(AW)) u_mem (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (wr_data),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  ptu_tick #(.AW(AW)) u_tick (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_vld  (rd_vld_r && (state_r == ptu_pkg::ST_TICK)),
    .rd_data (rd_data),
    .rd_addr (rd_addr_r),
    .dt      (dt_r),
    .force_v (force_r),
    .ctl     (tick_ctl),
    .wr_addr (tick_waddr),
    .wr_data (tick_wdata)
  );

  // Sequencer: next state, memory access, result assembly
  always_comb begin
    state_nxt = state_r;
    scan_nxt  = scan_r;
    live_nxt  = live_r;
    res_nxt   = res_r;
    rd_en     = 1'b0;
    rd_addr   = scan_r[AW-1:0];
    wr_en     = 1'b0;
    wr_addr   = scan_r[AW-1:0];
    wr_data   = '0;
    out_load  = 1'b0;

    case (state_r)
      ptu_pkg::ST_IDLE: begin
        if (in_fire) begin
          scan_nxt = '0;
          res_nxt  = '0;
          case (in_chan.op)
            ptu_pkg::OP_TICK: begin
              state_nxt = ptu_pkg::ST_TICK;
            end
            ptu_pkg::OP_SPAWN: begin
              if (n == '0) begin
                res_nxt.status = ptu_pkg::STS_FULL;
                state_nxt      = ptu_pkg::ST_DONE;
              end else begin
                state_nxt = ptu_pkg::ST_SCAN;
              end
            end
            ptu_pkg::OP_READ: begin
              res_nxt.slot = in_chan.slot_index;
              if (17'(in_chan.slot_index) < n_full) begin
                rd_en     = 1'b1;
                rd_addr   = AW'(in_chan.slot_index);
                state_nxt = ptu_pkg::ST_READ;
              end else begin
                res_nxt.status = ptu_pkg::STS_RANGE;
                state_nxt      = ptu_pkg::ST_DONE;
              end
            end
            default: begin
              state_nxt = ptu_pkg::ST_DONE;
            end
          endcase
        end
      end

      ptu_pkg::ST_CLEAR: begin
        if (scan_r < n) begin
          wr_en    = 1'b1;
          scan_nxt = scan_r + CW'(1);
        end else begin
          state_nxt = ptu_pkg::ST_IDLE;
        end
      end

      ptu_pkg::ST_TICK: begin
        wr_en   = tick_ctl.wr_en;
        wr_addr = tick_waddr;
        wr_data = tick_wdata;
        if (tick_ctl.kill && (live_r != '0)) begin
          live_nxt = live_r - 9'd1;
        end
        if (scan_r < n) begin
          rd_en    = 1'b1;
          scan_nxt = scan_r + CW'(1);
        end else if (!rd_vld_r && !tick_ctl.busy) begin
          state_nxt = ptu_pkg::ST_DONE;
        end
      end

      ptu_pkg::ST_SCAN: begin
        if (scan_r < n) begin
          rd_en    = 1'b1;
          scan_nxt = scan_r + CW'(1);
        end
        if (rd_vld_r) begin
          if (!rd_data.alive) begin
            wr_en        = 1'b1;
            wr_addr      = rd_addr_r;
            wr_data      = spawn_r;
            live_nxt     = live_r + 9'd1;
            res_nxt.slot = 8'(rd_addr_r);
            state_nxt    = ptu_pkg::ST_DONE;
          end else if ((CW'(rd_addr_r) + CW'(1)) == n) begin
            res_nxt.status = ptu_pkg::STS_FULL;
            state_nxt      = ptu_pkg::ST_DONE;
          end
        end
      end

      ptu_pkg::ST_READ: begin
        if (rd_vld_r) begin
          res_nxt.alive = rd_data.alive;
          res_nxt.pos   = rd_data.pos;
          res_nxt.vel   = rd_data.vel;
          res_nxt.life  = rd_data.life;
          state_nxt     = ptu_pkg::ST_DONE;
        end
      end

      ptu_pkg::ST_DONE: begin
        if (!out_vld_r || out_chan.ready) begin
          out_load  = 1'b1;
          state_nxt = ptu_pkg::ST_IDLE;
        end
      end

      default: begin
        state_nxt = ptu_pkg::ST_IDLE;
      end
    endcase

    // A new slot count restarts the clearing pass
    if (cfg_fire && (cfg_chan.index == ptu_pkg::CFG_ACTIVE)) begin
      state_nxt = ptu_pkg::ST_CLEAR;
      scan_nxt  = '0;
      live_nxt  = '0;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ptu_pkg::ST_IDLE;
      scan_r    <= '0;
      live_r    <= '0;
      act_r     <= '0;
      force_r   <= '0;
      rd_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      scan_r   <= scan_nxt;
      live_r   <= live_nxt;
      rd_vld_r <= rd_en;
      if (out_load) begin
        out_vld_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_vld_r <= 1'b0;
      end
      if (cfg_fire) begin
        case (cfg_chan.index)
          ptu_pkg::CFG_ACTIVE:  act_r      <= cfg_chan.data[8:0];
          ptu_pkg::CFG_FORCE_X: force_r[0] <= cfg_chan.data;
          ptu_pkg::CFG_FORCE_Y: force_r[1] <= cfg_chan.data;
          ptu_pkg::CFG_FORCE_Z: force_r[2] <= cfg_chan.data;
          default: ;
        endcase
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    rd_addr_r <= rd_addr;
    res_r     <= res_nxt;
    if (in_fire) begin
      dt_r          <= in_chan.step_time;
      spawn_r.alive <= 1'b1;
      spawn_r.life  <= {1'b0, in_chan.new_life};
      spawn_r.pos   <= {in_chan.new_pos_z, in_chan.new_pos_y, in_chan.new_pos_x};
      spawn_r.vel   <= {in_chan.new_vel_z, in_chan.new_vel_y, in_chan.new_vel_x};
    end
    // Load the result together with the live count after the operation
    if (out_load) begin
      out_r <= '{status: res_r.status, slot: res_r.slot, alive: res_r.alive,
                 pos: res_r.pos, vel: res_r.vel, life: res_r.life,
                 live_total: live_r};
    end
  end

  // Drive the result channel
  assign out_chan.valid      = out_vld_r;
  assign out_chan.status     = out_r.status;
  assign out_chan.slot       = out_r.slot;
  assign out_chan.is_alive   = out_r.alive;
  assign out_chan.pos_x_out  = out_r.pos[0];
  assign out_chan.pos_y_out  = out_r.pos[1];
  assign out_chan.pos_z_out  = out_r.pos[2];
  assign out_chan.vel_x_out  = out_r.vel[0];
  assign out_chan.vel_y_out  = out_r.vel[1];
  assign out_chan.vel_z_out  = out_r.vel[2];
  assign out_chan.life_left  = out_r.life;
  assign out_chan.live_total = out_r.live_total;

endmodule

// ===== rtl/ptu_mem.sv =====
`timescale 1ns / 1ps

module ptu_mem #(
  parameter int DEPTH = ptu_pkg::SLOTS_DEF,
  parameter int AW    = 8
) (
  input  logic                clk,
  input  logic                we,
  input  logic [AW-1:0]       waddr,
  input  ptu_pkg::ptu_slot_t  wdata,
  input  logic [AW-1:0]       raddr,
  output ptu_pkg::ptu_slot_t  rdata
);

  ptu_pkg::ptu_slot_t mem [DEPTH];
  ptu_pkg::ptu_slot_t rdata_r;

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/ptu_tick.sv =====
`timescale 1ns / 1ps

module ptu_tick #(
  parameter int AW = 8
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_vld,
  input  ptu_pkg::ptu_slot_t      rd_data,
  input  logic [AW-1:0]           rd_addr,
  input  logic [15:0]             dt,
  input  logic [2:0][31:0]        force_v,
  output ptu_pkg::ptu_tick_ctl_t  ctl,
  output logic [AW-1:0]           wr_addr,
  output ptu_pkg::ptu_slot_t      wr_data
);

  logic [2:0][31:0]   dv_r;
  logic               a_vld_r, b_vld_r;
  logic               a_kill_r, b_kill_r;
  logic [AW-1:0]      a_addr_r, b_addr_r;
  ptu_pkg::ptu_slot_t a_slot_r, b_slot_r;
  logic [2:0][31:0]   b_prod_r;
  ptu_pkg::ptu_slot_t a_slot_nxt;
  logic               a_kill_nxt;
  logic [31:0]        life_dec;

  // Velocity increment force*dt, refreshed every cycle
  always_ff @(posedge clk) begin
    for (int a = 0; a < 3; a++) begin
      dv_r[a] <= ptu_pkg::mul_dt(force_v[a], dt);
    end
  end

  // Stage A: update velocity, age live entries
  always_comb begin
    a_slot_nxt = rd_data;
    for (int a = 0; a < 3; a++) begin
      a_slot_nxt.vel[a] = ptu_pkg::sat_add(rd_data.vel[a], dv_r[a]);
    end
    life_dec = ptu_pkg::sat_add(rd_data.life, 32'd0 - {16'd0, dt});
    a_kill_nxt = rd_data.alive && ($signed(life_dec) <= 0);
    if (rd_data.alive) begin
      a_slot_nxt.life = life_dec;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
      b_vld_r <= 1'b0;
    end else begin
      a_vld_r <= in_vld;
      b_vld_r <= a_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    a_slot_r <= a_slot_nxt;
    a_kill_r <= a_kill_nxt;
    a_addr_r <= rd_addr;
    // Stage B: position deltas from the new velocity
    b_slot_r <= a_slot_r;
    b_kill_r <= a_kill_r;
    b_addr_r <= a_addr_r;
    for (int a = 0; a < 3; a++) begin
      b_prod_r[a] <= ptu_pkg::mul_dt(a_slot_r.vel[a], dt);
    end
  end

  // Stage C: move live entries, clear expired ones, write back
  always_comb begin
    wr_data = b_slot_r;
    if (b_kill_r) begin
      wr_data = '0;
    end else if (b_slot_r.alive) begin
      for (int a = 0; a < 3; a++) begin
        wr_data.pos[a] = ptu_pkg::sat_add(b_slot_r.pos[a], b_prod_r[a]);
      end
    end
  end

  assign wr_addr   = b_addr_r;
  assign ctl.wr_en = b_vld_r;
  assign ctl.kill  = b_vld_r && b_kill_r;
  assign ctl.busy  = a_vld_r || b_vld_r;

endmodule
